/* rtl/fbpa_pkg.sv */
// Shared types, codes and defaults of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned DefPoolDepth     = 1024;
  localparam int unsigned DefMaxBlocksReq  = 64;
  localparam int unsigned DefOffsetWidth   = 32;

  localparam int unsigned BsW     = 21;  // granule and granted_bytes
  localparam int unsigned PbW     = 11;  // pool_blocks and free_count
  localparam int unsigned FieldW  = 32;  // request_size, offsets
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic [BsW-1:0] BlockSizeRst  = BsW'(4096);
  localparam logic [PbW-1:0] PoolBlocksRst = PbW'(1024);

  // register select on paddr[2]
  typedef enum logic {
    REG_GRANULE     = 1'b0,
    REG_POOL_BLOCKS = 1'b1
  } reg_sel_e;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEMORY = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_POOL_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_FILL,
    S_ALLOC_MUL,
    S_ALLOC_CHK,
    S_ALLOC_POP,
    S_ALLOC_OUT,
    S_FREE_PUSH,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic    latch_in;
    logic    init_start;
    logic    init_step;
    logic    free_push;
    logic    alloc_pop;
    logic    load_alloc;
    logic    load_single;
    status_e st;
  } fbpa_cmd_t;

  typedef struct packed {
    logic init_done;
    logic req_zero;
    logic too_large;
    logic no_mem;
    logic pool_full;
    logic out_free;
    logic alloc_last;
  } fbpa_stat_t;

endpackage

/* rtl/fbpa_ctrl.sv */
// Sequencer of the allocator: decodes commands and steps the datapath.
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  output logic       in_ready_o,
  input  fbpa_stat_t stat_i,
  output fbpa_cmd_t  cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;
  cmd_e    cmd_in;

  assign cmd_in = cmd_e'(cmd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.st   = st_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          case (cmd_in)
            CMD_INIT: begin
              cmd_o.init_start = 1'b1;
              state_d          = S_INIT_FILL;
            end
            CMD_ALLOC: state_d = S_ALLOC_MUL;
            CMD_FREE:  state_d = S_FREE_PUSH;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_INIT_FILL: begin
        if (stat_i.init_done) begin
          st_d    = ST_OK;
          state_d = S_EMIT;
        end else begin
          cmd_o.init_step = 1'b1;
        end
      end
      // products of block size settle here
      S_ALLOC_MUL: state_d = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        state_d = S_EMIT;
        if (stat_i.req_zero) begin
          st_d = ST_OK;
        end else if (stat_i.too_large) begin
          st_d = ST_TOO_LARGE;
        end else if (stat_i.no_mem) begin
          st_d = ST_NO_MEMORY;
        end else begin
          state_d = S_ALLOC_POP;
        end
      end
      S_ALLOC_POP: begin
        cmd_o.alloc_pop = 1'b1;
        state_d         = S_ALLOC_OUT;
      end
      S_ALLOC_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_alloc = 1'b1;
          state_d = stat_i.alloc_last ? S_IDLE : S_ALLOC_POP;
        end
      end
      S_FREE_PUSH: begin
        if (stat_i.pool_full) begin
          st_d = ST_POOL_FULL;
        end else begin
          cmd_o.free_push = 1'b1;
          st_d            = ST_OK;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/fbpa_dp.sv */
// Datapath: free-list memory, pointers, size checks and the result register.
module fbpa_dp
  import fbpa_pkg::*;
#(
  parameter int unsigned POOL_DEPTH             = DefPoolDepth,
  parameter int unsigned MAX_BLOCKS_PER_REQUEST = DefMaxBlocksReq,
  parameter int unsigned OFFSET_WIDTH           = DefOffsetWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BsW-1:0]    granule_i,
  input  logic [PbW-1:0]    pool_blocks_i,
  input  logic [FieldW-1:0] request_size_i,
  input  logic [FieldW-1:0] block_offset_i,
  input  fbpa_cmd_t         cmd_i,
  output fbpa_stat_t        stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [FieldW-1:0] granted_offset_o,
  output logic [BsW-1:0]    granted_bytes_o,
  output logic [PbW-1:0]    free_count_o,
  output logic              last_o
);

  localparam int unsigned PtrW  = $clog2(POOL_DEPTH);
  localparam int unsigned CntW  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned MaxW  = $clog2(MAX_BLOCKS_PER_REQUEST + 1);
  localparam int unsigned ProdW = BsW + MaxW;
  localparam logic [PtrW-1:0] LastIdx  = PtrW'(POOL_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(POOL_DEPTH);
  localparam logic [MaxW-1:0] MaxBlk   = MaxW'(MAX_BLOCKS_PER_REQUEST);

  logic [OFFSET_WIDTH-1:0] mem_q [POOL_DEPTH];
  logic [OFFSET_WIDTH-1:0] rd_data_q;

  logic [PtrW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         init_left_q, init_left_d;
  logic [OFFSET_WIDTH-1:0] init_off_q;
  logic [FieldW-1:0]       left_q, off_q;
  logic [BsW-1:0]          fill_q;
  logic                    last_q;
  logic [ProdW-1:0]        prod_max_q, prod_cnt_q;

  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [FieldW-1:0]       out_off_q;
  logic [BsW-1:0]          out_bytes_q;
  logic [PbW-1:0]          out_count_q;
  logic                    out_last_q;

  logic [BsW-1:0]          bs;
  logic [MaxW-1:0]         cmin;
  logic [CntW-1:0]         init_n;
  logic [BsW-1:0]          fill;
  logic                    push;
  logic [OFFSET_WIDTH-1:0] push_data;
  logic                    out_free;

  // a zero block size behaves as one byte
  assign bs   = (granule_i == '0) ? BsW'(1) : granule_i;
  assign cmin = (32'(count_q) >= 32'(MAX_BLOCKS_PER_REQUEST)) ? MaxBlk : MaxW'(count_q);
  assign init_n = (32'(pool_blocks_i) > 32'(POOL_DEPTH)) ? DepthCnt : CntW'(pool_blocks_i);
  assign fill = (left_q <= 32'(bs)) ? left_q[BsW-1:0] : bs;

  assign push      = cmd_i.init_step || cmd_i.free_push;
  assign push_data = cmd_i.init_step ? init_off_q : OFFSET_WIDTH'(off_q);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    init_left_d = init_left_q;
    if (cmd_i.init_start) begin
      head_d      = '0;
      tail_d      = '0;
      count_d     = '0;
      init_left_d = init_n;
    end
    if (push) begin
      tail_d  = (tail_q == LastIdx) ? '0 : tail_q + PtrW'(1);
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.init_step) begin
      init_left_d = init_left_q - CntW'(1);
    end
    if (cmd_i.alloc_pop) begin
      head_d  = (head_q == LastIdx) ? '0 : head_q + PtrW'(1);
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      init_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      init_left_q <= init_left_d;
      if (cmd_i.load_alloc || cmd_i.load_single) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // free-list memory, one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[tail_q] <= push_data;
    end
    if (cmd_i.alloc_pop) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_max_q <= ProdW'(MaxBlk) * ProdW'(bs);
    prod_cnt_q <= ProdW'(cmin) * ProdW'(bs);
    if (cmd_i.latch_in) begin
      left_q <= request_size_i;
      off_q  <= block_offset_i;
    end
    if (cmd_i.init_start) begin
      init_off_q <= '0;
    end else if (cmd_i.init_step) begin
      init_off_q <= init_off_q + OFFSET_WIDTH'(bs);
    end
    if (cmd_i.alloc_pop) begin
      left_q <= left_q - FieldW'(fill);
      fill_q <= fill;
      last_q <= (left_q <= 32'(bs));
    end
    if (cmd_i.load_alloc) begin
      out_status_q <= ST_OK;
      out_off_q    <= FieldW'(rd_data_q);
      out_bytes_q  <= fill_q;
      out_count_q  <= PbW'(count_q);
      out_last_q   <= last_q;
    end else if (cmd_i.load_single) begin
      out_status_q <= cmd_i.st;
      out_off_q    <= '0;
      out_bytes_q  <= '0;
      out_count_q  <= PbW'(count_q);
      out_last_q   <= 1'b1;
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.init_done  = (init_left_q == '0);
    stat_o.req_zero   = (left_q == '0);
    stat_o.too_large  = (left_q > 32'(prod_max_q));
    stat_o.no_mem     = (left_q > 32'(prod_cnt_q));
    stat_o.pool_full  = (count_q >= DepthCnt);
    stat_o.out_free   = out_free;
    stat_o.alloc_last = last_q;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_offset_o = out_off_q;
  assign granted_bytes_o  = out_bytes_q;
  assign free_count_o     = out_count_q;
  assign last_o           = out_last_q;

endmodule

/* rtl/fixed_block_pool_allocator.sv */
// Fixed block pool allocator: FIFO free list of block offsets with init,
// allocate and free commands. One command is worked on at a time. Init
// writes min(pool_blocks, POOL_DEPTH) offsets, one free-list write a
// cycle; each allocated block passes a pop state and an output state,
// set by the single-port free-list memory and its registered read. A
// result waits in an output register, so the next command is taken
// while it is still pending. Refusals (too_large, no_memory, pool_full)
// give one beat with last set and change nothing. The free list is empty
// after reset; issue an init before allocating.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int unsigned POOL_DEPTH             = DefPoolDepth,
  parameter int unsigned MAX_BLOCKS_PER_REQUEST = DefMaxBlocksReq,
  parameter int unsigned OFFSET_WIDTH           = DefOffsetWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [FieldW-1:0] request_size_i,
  input  logic [FieldW-1:0] block_offset_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [FieldW-1:0] granted_offset_o,
  output logic [BsW-1:0]    granted_bytes_o,
  output logic [PbW-1:0]    free_count_o,
  output logic              last_o
);

  logic [BsW-1:0] granule_q;
  logic [PbW-1:0] pool_blocks_q;
  logic           cfg_wr;
  reg_sel_e       reg_sel;
  fbpa_cmd_t      cmd;
  fbpa_stat_t     stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_sel_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      granule_q     <= BlockSizeRst;
      pool_blocks_q <= PoolBlocksRst;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_GRANULE:     granule_q     <= pwdata[BsW-1:0];
        REG_POOL_BLOCKS: pool_blocks_q <= pwdata[PbW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRANULE:     prdata = PdataW'(granule_q);
      REG_POOL_BLOCKS: prdata = PdataW'(pool_blocks_q);
      default:         prdata = '0;
    endcase
  end

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbpa_dp #(
    .POOL_DEPTH             (POOL_DEPTH),
    .MAX_BLOCKS_PER_REQUEST (MAX_BLOCKS_PER_REQUEST),
    .OFFSET_WIDTH           (OFFSET_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .granule_i        (granule_q),
    .pool_blocks_i    (pool_blocks_q),
    .request_size_i   (request_size_i),
    .block_offset_i   (block_offset_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o),
    .granted_bytes_o  (granted_bytes_o),
    .free_count_o     (free_count_o),
    .last_o           (last_o)
  );

endmodule

/* tb/pool_grant_checker.sv */
// Checker for the block pool allocator: tracks the free list, predicts grant beats, compares.
module pool_grant_checker
  import fbpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [FieldW-1:0] request_size_i,
  input  logic [FieldW-1:0] block_offset_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [1:0]        status_o,
  input  logic [FieldW-1:0] granted_offset_o,
  input  logic [BsW-1:0]    granted_bytes_o,
  input  logic [PbW-1:0]    free_count_o,
  input  logic              last_o,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       beats_o
);

  localparam int unsigned Depth     = DefPoolDepth;
  localparam int unsigned MaxBlocks = DefMaxBlocksReq;
  localparam int unsigned IdxW      = $clog2(Depth);

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] offset;
    logic [BsW-1:0]    bytes;
    logic [PbW-1:0]    count;
    logic              last;
  } grant_t;

  grant_t            expected_grants[$];
  grant_t            oldest_grant;
  logic [FieldW-1:0] free_ring [Depth];
  logic [IdxW-1:0]   ring_head;
  logic [IdxW-1:0]   ring_tail;
  logic [PbW-1:0]    ring_count;
  logic [BsW-1:0]    granule_q;
  logic [PbW-1:0]    pool_blocks_q;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(Depth - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  // free_count carries the list occupancy after the beat is formed
  task automatic expect_beat(input status_e st, input logic [FieldW-1:0] off,
                             input logic [BsW-1:0] bytes, input logic last);
    grant_t g;
    g.status = st;
    g.offset = off;
    g.bytes  = bytes;
    g.count  = ring_count;
    g.last   = last;
    expected_grants = {expected_grants, g};
  endtask

  task automatic push_offset(input logic [FieldW-1:0] off);
    free_ring[ring_tail] = off;
    ring_tail  = next_slot(ring_tail);
    ring_count = ring_count + PbW'(1);
  endtask

  task automatic predict_command(input logic [1:0] cmd, input logic [FieldW-1:0] req,
                                 input logic [FieldW-1:0] off);
    longint unsigned   bs;
    longint unsigned   need;
    longint unsigned   used;
    longint unsigned   fill;
    longint unsigned   n;
    longint unsigned   k;
    logic [FieldW-1:0] popped;
    bs = (granule_q == '0) ? 1 : granule_q;
    case (cmd_e'(cmd))
      CMD_INIT: begin
        n = (pool_blocks_q > Depth) ? Depth : pool_blocks_q;
        ring_head  = '0;
        ring_tail  = '0;
        ring_count = '0;
        for (k = 0; k < n; k++) push_offset(FieldW'(k * bs));
        expect_beat(ST_OK, '0, '0, 1'b1);
      end
      CMD_ALLOC: begin
        need = req;
        need = (need + bs - 1) / bs;
        if (need == 0) begin
          expect_beat(ST_OK, '0, '0, 1'b1);
        end else if (need > MaxBlocks) begin
          expect_beat(ST_TOO_LARGE, '0, '0, 1'b1);
        end else if (need > ring_count) begin
          expect_beat(ST_NO_MEMORY, '0, '0, 1'b1);
        end else begin
          used = 0;
          for (k = 0; k < need; k++) begin
            fill = (req - used < bs) ? req - used : bs;
            used += fill;
            popped     = free_ring[ring_head];
            ring_head  = next_slot(ring_head);
            ring_count = ring_count - PbW'(1);
            expect_beat(ST_OK, popped, BsW'(fill), k + 1 == need);
          end
        end
      end
      CMD_FREE: begin
        if (ring_count >= Depth) begin
          expect_beat(ST_POOL_FULL, '0, '0, 1'b1);
        end else begin
          push_offset(off);
          expect_beat(ST_OK, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches_o++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_head     = '0;
      ring_tail     = '0;
      ring_count    = '0;
      granule_q     = BlockSizeRst;
      pool_blocks_q = PoolBlocksRst;
      expected_grants.delete();
      mismatches_o  = 0;
      beats_o       = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == PaddrW'({REG_GRANULE, 2'b00})) granule_q = pwdata[BsW-1:0];
        else if (paddr == PaddrW'({REG_POOL_BLOCKS, 2'b00})) pool_blocks_q = pwdata[PbW-1:0];
      end
      if (in_valid_i && in_ready_o) predict_command(cmd_i, request_size_i, block_offset_i);
      if (out_valid_o && out_ready_i) begin
        beats_o++;
        if (expected_grants.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected beat, expected none, actual status %0d offset 0x%0h",
                   $time, status_o, granted_offset_o);
        end else begin
          oldest_grant = expected_grants.pop_front();
          check_field("status", oldest_grant.status, status_o);
          check_field("granted_offset", oldest_grant.offset, granted_offset_o);
          check_field("granted_bytes", oldest_grant.bytes, granted_bytes_o);
          check_field("free_count", oldest_grant.count, free_count_o);
          check_field("last", oldest_grant.last, last_o);
        end
      end
    end
    pending_o = expected_grants.size();
  end

endmodule

/* tb/tb_fixed_block_pool_allocator.sv */
// Testbench top for the block pool allocator: clock, reset, stimulus and verdict.
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [PaddrW-1:0] paddr          = '0;
  logic [PdataW-1:0] pwdata         = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [1:0]        cmd_i          = CMD_NONE;
  logic [FieldW-1:0] request_size_i = '0;
  logic [FieldW-1:0] block_offset_i = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [1:0]        status_o;
  logic [FieldW-1:0] granted_offset_o;
  logic [BsW-1:0]    granted_bytes_o;
  logic [PbW-1:0]    free_count_o;
  logic              last_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned beats;
  int unsigned commands_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left    = 0;
  int unsigned ready_tick    = 0;
  logic [1:0]  ready_mode    = 2'd0;
  logic [BsW-1:0] cur_bs     = BlockSizeRst;
  logic [PbW-1:0] cur_pb     = PoolBlocksRst;

  fixed_block_pool_allocator uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .request_size_i, .block_offset_i,
    .out_valid_o, .out_ready_i, .status_o, .granted_offset_o, .granted_bytes_o,
    .free_count_o, .last_o
  );

  pool_grant_checker grant_chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .request_size_i, .block_offset_i,
    .out_valid_o, .out_ready_i, .status_o, .granted_offset_o, .granted_bytes_o,
    .free_count_o, .last_o,
    .mismatches_o(mismatches), .pending_o(pending), .beats_o(beats)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // receiver: drives out_ready_i in a randomly chosen stall mode
  always @(negedge clk_i) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick[5:0] == 6'd0) ready_mode <= 2'($urandom_range(3));
    case (ready_mode)
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= 1'($urandom_range(1));
      2'd2:    out_ready_i <= (ready_tick[1:0] == 2'd3);
      default: out_ready_i <= ($urandom_range(7) == 0);
    endcase
  end

  task automatic send_item(input cmd_e c, input logic [FieldW-1:0] rs,
                           input logic [FieldW-1:0] bo);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    request_size_i <= rs;
    block_offset_i <= bo;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    commands_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 10) : $urandom_range(7);
      gap = $urandom_range(6, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input reg_sel_e r, input logic [PdataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({r, 2'b00});
    // junk above the register width must be ignored
    pwdata  <= (r == REG_GRANULE) ? {11'($urandom), v[BsW-1:0]}
                                  : {21'($urandom), v[PbW-1:0]};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for the block to go idle, then load a new pool geometry
  task automatic reconfigure_pool(input logic [BsW-1:0] bs, input logic [PbW-1:0] pb);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    write_reg(REG_GRANULE, PdataW'(bs));
    write_reg(REG_POOL_BLOCKS, PdataW'(pb));
    cur_bs = bs;
    cur_pb = pb;
    settings_used++;
  endtask

  task automatic send_random_command();
    longint unsigned bsz;
    longint unsigned need;
    longint unsigned size;
    int unsigned     pick;
    bsz  = (cur_bs == '0) ? 1 : cur_bs;
    pick = $urandom_range(99);
    if (pick < 58) begin
      need = ($urandom_range(7) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
      size = (need - 1) * bsz + $urandom_range(bsz, 1);
      send_item(CMD_ALLOC, FieldW'(size), $urandom());
    end else if (pick < 66) begin
      case ($urandom_range(2))
        0:       size = 0;
        1:       size = 64 * bsz + $urandom_range(bsz, 1);
        default: size = $urandom();
      endcase
      send_item(CMD_ALLOC, FieldW'(size), $urandom());
    end else if (pick < 90) begin
      size = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(cur_pb) * bsz;
      send_item(CMD_FREE, $urandom(), FieldW'(size));
    end else if (pick < 96) begin
      send_item(CMD_INIT, $urandom(), $urandom());
    end else begin
      send_item(CMD_NONE, $urandom(), $urandom());
    end
  endtask

  initial begin
    int p;
    int i;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset geometry; list starts empty
    send_item(CMD_ALLOC, 32'd100, $urandom());
    send_item(CMD_FREE, $urandom(), 32'h1234_5678);
    send_item(CMD_ALLOC, 32'd1, $urandom());
    send_item(CMD_NONE, $urandom(), $urandom());
    send_item(CMD_INIT, $urandom(), $urandom());
    send_item(CMD_FREE, $urandom(), 32'hDEAD_BEEF);
    send_item(CMD_ALLOC, 32'd0, $urandom());
    send_item(CMD_ALLOC, 32'd262144, $urandom());
    send_item(CMD_ALLOC, 32'd262145, $urandom());
    send_item(CMD_ALLOC, 32'hFFFF_FFFF, $urandom());
    send_item(CMD_ALLOC, 32'd1, $urandom());
    send_item(CMD_ALLOC, 32'd4097, $urandom());
    send_item(CMD_FREE, $urandom(), 32'hFFFF_FFFF);
    send_item(CMD_FREE, $urandom(), 32'h0000_0000);

    // zero block size behaves as one byte, oversized pool is clamped
    reconfigure_pool('0, PbW'(2047));
    send_item(CMD_INIT, $urandom(), $urandom());
    send_item(CMD_ALLOC, 32'd64, $urandom());
    send_item(CMD_ALLOC, 32'd65, $urandom());
    send_item(CMD_ALLOC, 32'd3, $urandom());

    // one-megabyte granule, empty pool after init
    reconfigure_pool(BsW'(1048576), '0);
    send_item(CMD_INIT, $urandom(), $urandom());
    send_item(CMD_ALLOC, 32'd1, $urandom());
    send_item(CMD_FREE, $urandom(), 32'hABCD_0123);
    send_item(CMD_ALLOC, 32'd1048577, $urandom());
    send_item(CMD_ALLOC, 32'd5, $urandom());

    for (p = 0; p < 6; p++) begin
      case (p)
        0:       reconfigure_pool(BsW'(4096), PbW'(24));
        1:       reconfigure_pool(BsW'(1), PbW'(64));
        2:       reconfigure_pool(BsW'(21'h1F_FFFF), PbW'(12));
        3:       reconfigure_pool(BsW'($urandom_range(3000, 2)), PbW'($urandom_range(100, 8)));
        4:       reconfigure_pool(BsW'(512), PbW'(1024));
        default: reconfigure_pool(BsW'($urandom()), PbW'($urandom_range(200)));
      endcase
      send_item(CMD_INIT, $urandom(), $urandom());
      for (i = 0; i < 14; i++) send_random_command();
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("Ran %0d commands over %0d pool settings plus reset values.",
             commands_sent, settings_used);
    $display("Checked %0d grant beats, %0d mismatches.", beats, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
